/* rtl/mwsn_pkg.sv */
package mwsn_pkg;

  localparam int SpeedW   = 16;
  localparam int SumW     = 18;
  localparam int MagW     = 15;
  localparam int ProdW    = 2 * MagW;
  localparam int Lanes    = 4;
  // one quotient bit per divider stage
  localparam int DivSteps = MagW;

  localparam int LaneLf = 0;
  localparam int LaneLb = 1;
  localparam int LaneRf = 2;
  localparam int LaneRb = 3;

  localparam logic [MagW-1:0]        LimitReset = 15'd8000;
  localparam logic signed [SumW-1:0] SumMax     = 18'sd32767;
  localparam logic signed [SumW-1:0] SumMin     = -18'sd32767;

  typedef logic signed [SpeedW-1:0] speed_t;
  typedef logic [MagW-1:0]          mag_t;

  typedef struct packed {
    mag_t rem;
    mag_t dvd;
    mag_t quo;
  } div_lane_t;

  typedef struct packed {
    logic [Lanes-1:0]            neg;
    mag_t                        divisor;
    div_lane_t [Lanes-1:0]       lane;
  } div_item_t;

  function automatic speed_t clamp_sum(input logic signed [SumW-1:0] v);
    speed_t r;
    if (v > SumMax) begin
      r = speed_t'(SumMax[SpeedW-1:0]);
    end else if (v < SumMin) begin
      r = speed_t'(SumMin[SpeedW-1:0]);
    end else begin
      r = v[SpeedW-1:0];
    end
    return r;
  endfunction

  // input is already clamped to +-32767, so the magnitude fits in MagW bits
  function automatic mag_t magnitude(input speed_t v);
    logic [SpeedW-1:0] a;
    a = v[SpeedW-1] ? (~v + 16'd1) : v;
    return a[MagW-1:0];
  endfunction

endpackage

/* rtl/mwsn_front.sv */
module mwsn_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mwsn_pkg::speed_t    speed_x,
  input  mwsn_pkg::speed_t    speed_y,
  input  mwsn_pkg::speed_t    turn_rate,
  input  mwsn_pkg::mag_t      limit,
  output logic                out_valid,
  input  logic                out_ready,
  output mwsn_pkg::div_item_t out_item
);
  import mwsn_pkg::*;

  // stage 1: wheel sums, clamped
  logic   s1_valid;
  logic   s1_ready;
  speed_t s1_wheel [Lanes];

  // stage 2: sign, magnitude, peak, scale operands
  logic             s2_valid;
  logic             s2_ready;
  logic [Lanes-1:0] s2_neg;
  mag_t             s2_mag [Lanes];
  mag_t             s2_factor;
  mag_t             s2_divisor;

  // stage 3: products split into divider start state
  logic      s3_valid;
  logic      s3_ready;
  div_item_t s3_item;

  logic signed [SumW-1:0] vx, vy, wt;
  mag_t                   m [Lanes];
  mag_t                   p01, p23, peak;
  logic                   scale;
  logic [ProdW-1:0]       prod [Lanes];

  assign vx = SumW'(speed_x);
  assign vy = SumW'(speed_y);
  assign wt = SumW'(turn_rate);

  assign s3_ready = !s3_valid || out_ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= in_valid;
      if (s2_ready) s2_valid <= s1_valid;
      if (s3_ready) s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_wheel[LaneLf] <= clamp_sum(vx + vy + wt);
      s1_wheel[LaneLb] <= clamp_sum(vx - vy - wt);
      s1_wheel[LaneRf] <= clamp_sum(vx - vy + wt);
      s1_wheel[LaneRb] <= clamp_sum(vx + vy - wt);
    end
  end

  always_comb begin
    for (int k = 0; k < Lanes; k++) begin
      m[k] = magnitude(s1_wheel[k]);
    end
    p01   = (m[0] > m[1]) ? m[0] : m[1];
    p23   = (m[2] > m[3]) ? m[2] : m[3];
    peak  = (p01 > p23) ? p01 : p23;
    scale = limit < peak;
  end

  // unscaled wheels go through the divider as |w| * 1 / 1
  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      for (int k = 0; k < Lanes; k++) begin
        s2_neg[k] <= s1_wheel[k][SpeedW-1];
        s2_mag[k] <= m[k];
      end
      s2_factor  <= scale ? limit : mag_t'(1);
      s2_divisor <= scale ? peak : mag_t'(1);
    end
  end

  always_comb begin
    for (int k = 0; k < Lanes; k++) begin
      prod[k] = ProdW'(s2_mag[k]) * ProdW'(s2_factor);
    end
  end

  // product < divisor * 2^MagW, so the upper half already sits below the divisor
  always_ff @(posedge clk) begin
    if (s3_ready && s2_valid) begin
      s3_item.neg     <= s2_neg;
      s3_item.divisor <= s2_divisor;
      for (int k = 0; k < Lanes; k++) begin
        s3_item.lane[k].rem <= prod[k][ProdW-1:MagW];
        s3_item.lane[k].dvd <= prod[k][MagW-1:0];
        s3_item.lane[k].quo <= '0;
      end
    end
  end

  assign out_valid = s3_valid;
  assign out_item  = s3_item;

endmodule

/* rtl/mwsn_div_step.sv */
module mwsn_div_step (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mwsn_pkg::div_item_t in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output mwsn_pkg::div_item_t out_item
);
  import mwsn_pkg::*;

  logic      valid;
  div_item_t item;
  div_item_t item_next;

  logic [MagW:0] trial [Lanes];
  logic [MagW:0] diff  [Lanes];
  logic          ge    [Lanes];

  assign in_ready = !valid || out_ready;

  // one restoring step per lane: shift in the next dividend bit, subtract if it fits
  always_comb begin
    item_next.neg     = in_item.neg;
    item_next.divisor = in_item.divisor;
    for (int k = 0; k < Lanes; k++) begin
      trial[k] = {in_item.lane[k].rem, in_item.lane[k].dvd[MagW-1]};
      diff[k]  = trial[k] - {1'b0, in_item.divisor};
      ge[k]    = trial[k] >= {1'b0, in_item.divisor};
      item_next.lane[k].rem = ge[k] ? diff[k][MagW-1:0] : trial[k][MagW-1:0];
      item_next.lane[k].dvd = {in_item.lane[k].dvd[MagW-2:0], 1'b0};
      item_next.lane[k].quo = {in_item.lane[k].quo[MagW-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= item_next;
    end
  end

  assign out_valid = valid;
  assign out_item  = item;

endmodule

/* rtl/mwsn_finish.sv */
module mwsn_finish (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mwsn_pkg::div_item_t in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output mwsn_pkg::speed_t    left_front_target,
  output mwsn_pkg::speed_t    left_back_target,
  output mwsn_pkg::speed_t    right_front_target,
  output mwsn_pkg::speed_t    right_back_target
);
  import mwsn_pkg::*;

  logic   valid;
  speed_t q   [Lanes];
  speed_t neg [Lanes];

  assign in_ready = !valid || out_ready;

  always_comb begin
    for (int k = 0; k < Lanes; k++) begin
      q[k]   = speed_t'({1'b0, in_item.lane[k].quo});
      neg[k] = -q[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  // apply wheel sign; right side is mirrored
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      left_front_target  <= in_item.neg[LaneLf] ? neg[LaneLf] : q[LaneLf];
      left_back_target   <= in_item.neg[LaneLb] ? neg[LaneLb] : q[LaneLb];
      right_front_target <= in_item.neg[LaneRf] ? q[LaneRf] : neg[LaneRf];
      right_back_target  <= in_item.neg[LaneRb] ? q[LaneRb] : neg[LaneRb];
    end
  end

  assign out_valid = valid;

endmodule

/* rtl/mecanum_wheel_speed_normalize.sv */
// Mecanum wheel mixer with common-ratio limiting. Each command (speed_x,
// speed_y, turn_rate) yields one result of four wheel targets: the sums
// x+y+t, x-y-t, x-y+t and x+y-t, each clamped to +-32767. When the largest
// clamped magnitude exceeds max_wheel_speed, every wheel becomes
// sum * max_wheel_speed / peak, truncated toward zero, so the wheels keep
// their ratios. The two right-side targets come out negated. The pipeline
// accepts one command per clock while the output is not stalled, and each
// passes through three front stages (sums, peak search, 15x15 products),
// a 15-stage restoring divider that settles one quotient bit per stage for
// all four wheels at once, and the output register. Every stage holds its
// own valid bit, so a stall on the output backs up only as far as needed
// and empty stages still take new commands. max_wheel_speed resets to 8000
// and is loaded on a transfer on the cfg channel, which is always ready;
// write it only while no command is in flight.
module mecanum_wheel_speed_normalize (
  input  logic             clk,
  input  logic             rst,
  // command channel
  input  logic             in_valid,
  output logic             in_ready,
  input  mwsn_pkg::speed_t speed_x,
  input  mwsn_pkg::speed_t speed_y,
  input  mwsn_pkg::speed_t turn_rate,
  // wheel target channel
  output logic             out_valid,
  input  logic             out_ready,
  output mwsn_pkg::speed_t left_front_target,
  output mwsn_pkg::speed_t left_back_target,
  output mwsn_pkg::speed_t right_front_target,
  output mwsn_pkg::speed_t right_back_target,
  // configuration
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  mwsn_pkg::mag_t   max_wheel_speed
);
  import mwsn_pkg::*;

  // wheel speed limit register
  mag_t limit;

  // divider chain: entry 0 is the front output, entry DivSteps feeds the finish stage
  logic [DivSteps:0] chain_valid;
  logic [DivSteps:0] chain_ready;
  div_item_t         chain_item [DivSteps+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LimitReset;
    end else if (cfg_valid && cfg_ready) begin
      limit <= max_wheel_speed;
    end
  end

  // sums, peak and products
  mwsn_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .speed_x   (speed_x),
    .speed_y   (speed_y),
    .turn_rate (turn_rate),
    .limit     (limit),
    .out_valid (chain_valid[0]),
    .out_ready (chain_ready[0]),
    .out_item  (chain_item[0])
  );

  // one quotient bit per stage, most significant first
  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    mwsn_div_step u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[i]),
      .in_ready  (chain_ready[i]),
      .in_item   (chain_item[i]),
      .out_valid (chain_valid[i+1]),
      .out_ready (chain_ready[i+1]),
      .out_item  (chain_item[i+1])
    );
  end

  // sign, right-side mirror and output register
  mwsn_finish u_finish (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (chain_valid[DivSteps]),
    .in_ready           (chain_ready[DivSteps]),
    .in_item            (chain_item[DivSteps]),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .left_front_target  (left_front_target),
    .left_back_target   (left_back_target),
    .right_front_target (right_front_target),
    .right_back_target  (right_back_target)
  );

endmodule

/* rtl/mwsn_checker.sv */
module mwsn_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic signed [15:0]  speed_x,
  input logic signed [15:0]  speed_y,
  input logic signed [15:0]  turn_rate,
  input logic                out_valid,
  input logic                out_ready,
  input logic signed [15:0]  left_front_target,
  input logic signed [15:0]  left_back_target,
  input logic signed [15:0]  right_front_target,
  input logic signed [15:0]  right_back_target,
  input logic                cfg_valid,
  input logic                cfg_ready,
  input logic [14:0]         max_wheel_speed
);
  import mwsn_pkg::*;

  mag_t   lim_seen;
  speed_t lim_pos;
  speed_t lim_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      lim_seen <= LimitReset;
    end else if (cfg_valid && cfg_ready) begin
      lim_seen <= max_wheel_speed;
    end
  end

  assign lim_pos = speed_t'({1'b0, lim_seen});
  assign lim_neg = -lim_pos;

  // hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid
      && $stable(left_front_target) && $stable(left_back_target)
      && $stable(right_front_target) && $stable(right_back_target))
    else $error("stalled wheel result changed");

  // an empty output register means every stage can advance
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("command refused with empty output");

  // every wheel stays within the configured limit after scaling
  a_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      left_front_target <= lim_pos && left_front_target >= lim_neg
      && left_back_target <= lim_pos && left_back_target >= lim_neg
      && right_front_target <= lim_pos && right_front_target >= lim_neg
      && right_back_target <= lim_pos && right_back_target >= lim_neg)
    else $error("wheel target exceeds speed limit");

  // no transfer comes out of a freshly reset pipeline
  a_reset: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind mecanum_wheel_speed_normalize mwsn_checker u_checker (.*);

/* tb/mecanum_wheel_speed_normalize_test.sv */
`timescale 1ns / 100ps

module mecanum_wheel_speed_normalize_test;
  import mwsn_pkg::speed_t;
  import mwsn_pkg::mag_t;

  localparam int WatchdogLimit = 4000;
  localparam int DrainCycles   = 40;
  localparam int PhaseItems    = 150;
  localparam int NumPhases     = 9;
  localparam int NumDirected   = 23;
  // marker in the limit plan: draw a fresh limit at random
  localparam int RandLimit     = -1;

  // one result: four wheel targets, right side already negated
  typedef struct packed {
    speed_t lf;
    speed_t lb;
    speed_t rf;
    speed_t rb;
  } wheels_t;

  // one directed command; want holds the result only where typed is set
  typedef struct {
    speed_t  x;
    speed_t  y;
    speed_t  t;
    bit      typed;
    wheels_t want;
  } cmd_row_t;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   in_valid = 1'b0;
  logic   in_ready;
  speed_t speed_x = '0;
  speed_t speed_y = '0;
  speed_t turn_rate = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  speed_t left_front_target;
  speed_t left_back_target;
  speed_t right_front_target;
  speed_t right_back_target;
  logic   cfg_valid = 1'b0;
  logic   cfg_ready;
  mag_t   max_wheel_speed = '0;

  // wheel targets owed by the block, oldest first
  wheels_t pending_wheels[$];
  mag_t    wheel_limit = mwsn_pkg::LimitReset;
  int      mismatches = 0;
  int      quiet_cycles = 0;
  int      ready_hold = 0;
  bit      no_idle = 1'b0;

  // Directed commands, all run under the reset limit of 8000. Rows with typed
  // set carry an answer that is plain by eye: zero, unit axes, full-scale
  // saturation, a peak right at the limit and one just above it.
  cmd_row_t directed_cmds [NumDirected] = '{
    '{0,      0,      0,      1'b1, '{0,     0,     0,     0}},
    '{1000,   0,      0,      1'b1, '{1000,  1000,  -1000, -1000}},
    '{0,      1000,   0,      1'b1, '{1000,  -1000, 1000,  -1000}},
    '{0,      0,      1000,   1'b1, '{1000,  -1000, -1000, 1000}},
    '{32767,  32767,  32767,  1'b1, '{8000,  -8000, -8000, -8000}},
    '{-32768, -32768, -32768, 1'b1, '{-8000, 8000,  8000,  8000}},
    '{8000,   0,      0,      1'b1, '{8000,  8000,  -8000, -8000}},
    '{8001,   0,      0,      1'b1, '{8000,  8000,  -8000, -8000}},
    '{-32768, 0,      0,      1'b1, '{-8000, -8000, 8000,  8000}},
    '{32767,  0,      0,      1'b1, '{8000,  8000,  -8000, -8000}},
    '{3000,   2000,   1000,   1'b0, '{0, 0, 0, 0}},
    '{-3000,  2500,   -1999,  1'b0, '{0, 0, 0, 0}},
    '{20000,  20000,  0,      1'b0, '{0, 0, 0, 0}},
    '{16384,  -16384, 16383,  1'b0, '{0, 0, 0, 0}},
    '{7999,   1,      0,      1'b0, '{0, 0, 0, 0}},
    '{5,      7,      -3,     1'b0, '{0, 0, 0, 0}},
    '{12345,  -6789,  4321,   1'b0, '{0, 0, 0, 0}},
    '{-1,     -1,     -1,     1'b0, '{0, 0, 0, 0}},
    '{32767,  -32768, 32767,  1'b0, '{0, 0, 0, 0}},
    '{0,      -32768, 0,      1'b0, '{0, 0, 0, 0}},
    '{0,      0,      -32768, 1'b0, '{0, 0, 0, 0}},
    '{0,      32767,  0,      1'b0, '{0, 0, 0, 0}},
    '{-12000, -12000, -12000, 1'b0, '{0, 0, 0, 0}}
  };

  // limits for the random phases: zero, full scale, one, 32766, 8000, 2 and random draws
  int limit_plan [NumPhases] = '{0, 32767, 1, 32766, RandLimit, RandLimit, 8000,
                                 RandLimit, 2};

  mecanum_wheel_speed_normalize u_dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .speed_x            (speed_x),
    .speed_y            (speed_y),
    .turn_rate          (turn_rate),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .left_front_target  (left_front_target),
    .left_back_target   (left_back_target),
    .right_front_target (right_front_target),
    .right_back_target  (right_back_target),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .max_wheel_speed    (max_wheel_speed)
  );

  always #10 clk = ~clk;

  // Saturate one wheel sum to the symmetric 16-bit range.
  function automatic int sat_wheel(input int v);
    if (v > 32767) begin
      return 32767;
    end else if (v < -32767) begin
      return -32767;
    end
    return v;
  endfunction

  // Mix a chassis command into wheel targets and scale all four by the same
  // ratio when the largest one is over the limit.
  function automatic wheels_t mix_wheels(input speed_t x, input speed_t y,
                                         input speed_t t, input mag_t lim);
    int      sums [4];
    int      peak;
    int      mag;
    longint  prod;
    wheels_t w;
    sums[0] = sat_wheel(int'(x) + int'(y) + int'(t));
    sums[1] = sat_wheel(int'(x) - int'(y) - int'(t));
    sums[2] = sat_wheel(int'(x) - int'(y) + int'(t));
    sums[3] = sat_wheel(int'(x) + int'(y) - int'(t));
    peak = 0;
    for (int k = 0; k < 4; k++) begin
      mag = (sums[k] < 0) ? -sums[k] : sums[k];
      if (mag > peak) begin
        peak = mag;
      end
    end
    if (int'(lim) < peak) begin
      for (int k = 0; k < 4; k++) begin
        // signed divide truncates toward zero
        prod = longint'(sums[k]) * longint'(lim);
        sums[k] = int'(prod / longint'(peak));
      end
    end
    w.lf = speed_t'(sums[0]);
    w.lb = speed_t'(sums[1]);
    w.rf = speed_t'(-sums[2]);
    w.rb = speed_t'(-sums[3]);
    return w;
  endfunction

  // Pick an idle length: mostly none, sometimes a few cycles, rarely a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      return 0;
    end else if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 60);
  endfunction

  // Draw a signed value within +-span, saturated to the 16-bit field.
  function automatic speed_t around_zero(input int span);
    int v;
    v = int'($urandom_range(0, 2 * span)) - span;
    if (v > 32767) begin
      v = 32767;
    end else if (v < -32768) begin
      v = -32768;
    end
    return speed_t'(v);
  endfunction

  // Draw one field from the corner values or anywhere in range.
  function automatic speed_t corner_or_any();
    case ($urandom_range(0, 7))
      0: return speed_t'(-32768);
      1: return speed_t'(-32767);
      2: return speed_t'(-1);
      3: return speed_t'(0);
      4: return speed_t'(1);
      5: return speed_t'(32767);
      default: return speed_t'($urandom());
    endcase
  endfunction

  task automatic check_wheel(input string name, input speed_t want, input speed_t got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Present one command, hold it until the transfer, then log what it owes.
  task automatic send_cmd(input speed_t x, input speed_t y, input speed_t t,
                          input bit typed, input wheels_t want);
    int gap;
    in_valid  <= 1'b1;
    speed_x   <= x;
    speed_y   <= y;
    turn_rate <= t;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    pending_wheels.push_back(typed ? want : mix_wheels(x, y, t, wheel_limit));
    gap = no_idle ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and hold off until every owed result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_wheels.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Write the wheel limit; the block must be idle.
  task automatic set_limit(input mag_t lim);
    cfg_valid       <= 1'b1;
    max_wheel_speed <= lim;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    wheel_limit = lim;
    cfg_valid <= 1'b0;
  endtask

  // Random command shaped around the current limit so that both the unscaled
  // and the scaled paths, the exact-limit boundary and saturation all see use.
  task automatic send_random();
    int      sel;
    int      lim;
    int      edge_v;
    speed_t  x;
    speed_t  y;
    speed_t  t;
    wheels_t none;
    none = '0;
    lim = int'(wheel_limit);
    sel = $urandom_range(0, 99);
    if (sel < 35) begin
      x = speed_t'($urandom());
      y = speed_t'($urandom());
      t = speed_t'($urandom());
    end else if (sel < 60) begin
      // stay under the limit
      x = around_zero(lim / 3);
      y = around_zero(lim / 3);
      t = around_zero(lim / 3);
    end else if (sel < 72) begin
      // put the peak on one axis at limit-1, limit or limit+1
      edge_v = lim + int'($urandom_range(0, 2)) - 1;
      if (edge_v > 32767) begin
        edge_v = 32767;
      end else if (edge_v < 0) begin
        edge_v = 0;
      end
      if ($urandom_range(0, 1) == 1) begin
        edge_v = -edge_v;
      end
      x = '0;
      y = '0;
      t = '0;
      case ($urandom_range(0, 2))
        0: x = speed_t'(edge_v);
        1: y = speed_t'(edge_v);
        default: t = speed_t'(edge_v);
      endcase
    end else if (sel < 85) begin
      x = corner_or_any();
      y = corner_or_any();
      t = corner_or_any();
    end else begin
      // sums land near the limit from either side
      x = around_zero(lim / 2 + 1);
      y = around_zero(lim / 2 + 1);
      t = around_zero(lim / 2 + 1);
    end
    send_cmd(x, y, t, 1'b0, none);
  endtask

  // Check each result transfer against the oldest owed one, and drive
  // out_ready with random stalls.
  always @(posedge clk) begin
    wheels_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_wheels.size() == 0) begin
        mismatches++;
        $display("%0t: result transfer with nothing expected, actual %0d %0d %0d %0d",
                 $time, left_front_target, left_back_target,
                 right_front_target, right_back_target);
      end else begin
        want = pending_wheels.pop_front();
        check_wheel("left_front_target", want.lf, left_front_target);
        check_wheel("left_back_target", want.lb, left_back_target);
        check_wheel("right_front_target", want.rf, right_front_target);
        check_wheel("right_back_target", want.rb, right_back_target);
      end
    end
    if (ready_hold > 0) begin
      out_ready <= 1'b0;
      ready_hold--;
    end else begin
      out_ready <= 1'b1;
      ready_hold = no_idle ? 0 : idle_len();
    end
  end

  // End the run when no transfer of any kind happens for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: watchdog, no transfer for %0d cycles", $time, quiet_cycles);
      $display("mecanum_wheel_speed_normalize_test NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int lim;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part under the reset limit
    foreach (directed_cmds[i]) begin
      send_cmd(directed_cmds[i].x, directed_cmds[i].y, directed_cmds[i].t,
               directed_cmds[i].typed, directed_cmds[i].want);
    end
    drain();

    // random phases, each under a new limit written while idle
    for (int p = 0; p < NumPhases; p++) begin
      lim = (limit_plan[p] == RandLimit) ? int'($urandom_range(0, 32767)) : limit_plan[p];
      set_limit(mag_t'(lim));
      // run one phase flat out on both sides
      no_idle = (p == 2);
      for (int n = 0; n < PhaseItems; n++) begin
        send_random();
        // now and then hold the sender until the pipeline is empty
        if ($urandom_range(0, 199) == 0) begin
          drain();
        end
      end
      drain();
    end
    no_idle = 1'b0;

    // let any stray result show up before the verdict
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("mecanum_wheel_speed_normalize_test OK");
    end else begin
      $display("mecanum_wheel_speed_normalize_test NOT OK");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/mwsn_pkg.sv
rtl/mwsn_front.sv
rtl/mwsn_div_step.sv
rtl/mwsn_finish.sv
rtl/mecanum_wheel_speed_normalize.sv
rtl/mwsn_checker.sv
tb/mecanum_wheel_speed_normalize_test.sv
